/* rtl/core/cmfs_pkg.sv */
// Types and constants shared by the cube map face select unit.
package cmfs_pkg;

    localparam int COMP_BITS = 16;
    localparam int FRAC_BITS = 16;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    localparam logic [FRAC_BITS-1:0] COORD_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS-1:0] COORD_MAX  = {FRAC_BITS{1'b1}};

    typedef struct packed {
        logic signed [COMP_BITS-1:0] dir_x;
        logic signed [COMP_BITS-1:0] dir_y;
        logic signed [COMP_BITS-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic [2:0]           face;
        logic [FRAC_BITS-1:0] coord_u;
        logic [FRAC_BITS-1:0] coord_v;
        logic                 zero_vector;
    } result_t;

    // after face selection
    typedef struct packed {
        logic [2:0]                face;
        logic [COMP_BITS-1:0]      major;
        logic signed [COMP_BITS:0] minor_u;
        logic signed [COMP_BITS:0] minor_v;
    } sel_t;

    // one divider stage: shared divisor, two remainders and quotients
    typedef struct packed {
        logic [2:0]           face;
        logic                 zero;
        logic                 sat_u;
        logic                 sat_v;
        logic [COMP_BITS-1:0] div;
        logic [COMP_BITS:0]   rem_u;
        logic [COMP_BITS:0]   rem_v;
        logic [FRAC_BITS-1:0] quo_u;
        logic [FRAC_BITS-1:0] quo_v;
    } div_t;

endpackage

/* rtl/core/cube_map_face_select_unit.sv */
// Cube map face select: direction vector to face index and Q0.16 texture coordinates.
// Fully pipelined: one item may start in every cycle and busy is always low. Each result
// appears on result with done high for one cycle. Between start and done an item passes through the
// input capture, face selection and offset/saturation registers, then the stages of the restoring
// divider that produces u and v, STEPS_PER_STAGE (default 4) quotient bits per stage, and last the
// output register. Results are not held: the receiver must take each one in the cycle it is shown.
module cube_map_face_select_unit #(
    parameter int STEPS_PER_STAGE = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmfs_pkg::dir_t    dir,
    output logic              done,
    output cmfs_pkg::result_t result
);

    localparam int CB     = cmfs_pkg::COMP_BITS;
    localparam int FB     = cmfs_pkg::FRAC_BITS;
    localparam int NSTAGE = (FB + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int LAT    = NSTAGE + 4;

    // ---------------- stage 1: input capture
    logic           in_valid_reg;
    cmfs_pkg::dir_t in_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            in_reg <= dir;
    end

    // ---------------- stage 2: face selection
    logic           sel_valid_reg;
    cmfs_pkg::sel_t sel_reg;
    cmfs_pkg::sel_t sel_next;

    always_comb
    begin
        logic signed [CB:0] x, y, z, nx, nz;
        logic [CB-1:0]      ax, ay, az;
        logic               x_major, y_major, z_major;
        y  = {in_reg.dir_y[CB-1], in_reg.dir_y};
        z  = {in_reg.dir_z[CB-1], in_reg.dir_z};
        x  = {in_reg.dir_x[CB-1], in_reg.dir_x};
        nx = -x;
        nz = -z;
        ax = x[CB] ? nx[CB-1:0] : x[CB-1:0];
        ay = y[CB] ? (CB'(~y[CB-1:0]) + CB'(1)) : y[CB-1:0];
        az = z[CB] ? nz[CB-1:0] : z[CB-1:0];
        x_major = (ax >= ay) && (ax >= az);
        y_major = (ay >= ax) && (ay >= az);
        z_major = (az >= ax) && (az >= ay);

        // later tests override earlier ones; zero is not positive
        sel_next.face    = cmfs_pkg::FACE_PX;
        sel_next.major   = ax;
        sel_next.minor_u = nz;
        sel_next.minor_v = y;
        if ((x[CB] || x == '0) && x_major)
        begin
            sel_next.face    = cmfs_pkg::FACE_NX;
            sel_next.major   = ax;
            sel_next.minor_u = z;
            sel_next.minor_v = y;
        end
        if (!y[CB] && y != '0 && y_major)
        begin
            sel_next.face    = cmfs_pkg::FACE_PY;
            sel_next.major   = ay;
            sel_next.minor_u = x;
            sel_next.minor_v = nz;
        end
        if ((y[CB] || y == '0) && y_major)
        begin
            sel_next.face    = cmfs_pkg::FACE_NY;
            sel_next.major   = ay;
            sel_next.minor_u = x;
            sel_next.minor_v = z;
        end
        if (!z[CB] && z != '0 && z_major)
        begin
            sel_next.face    = cmfs_pkg::FACE_PZ;
            sel_next.major   = az;
            sel_next.minor_u = x;
            sel_next.minor_v = y;
        end
        if ((z[CB] || z == '0) && z_major)
        begin
            sel_next.face    = cmfs_pkg::FACE_NZ;
            sel_next.major   = az;
            sel_next.minor_u = nx;
            sel_next.minor_v = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else
            sel_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            sel_reg <= sel_next;
    end

    // ---------------- stage 3: offset to [0, 2*major], full-scale detect
    logic           off_valid_reg;
    cmfs_pkg::div_t off_reg;
    cmfs_pkg::div_t off_next;

    always_comb
    begin
        logic signed [CB:0] major_s;
        logic signed [CB:0] sum_u, sum_v;
        major_s = {1'b0, sel_reg.major};
        sum_u   = sel_reg.minor_u + major_s;
        sum_v   = sel_reg.minor_v + major_s;

        off_next.face  = sel_reg.face;
        off_next.zero  = (sel_reg.major == '0);
        off_next.sat_u = (sel_reg.minor_u == major_s);
        off_next.sat_v = (sel_reg.minor_v == major_s);
        off_next.div   = sel_reg.major;
        off_next.rem_u = sum_u;
        off_next.rem_v = sum_v;
        off_next.quo_u = '0;
        off_next.quo_v = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            off_valid_reg <= 1'b0;
        else
            off_valid_reg <= sel_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (sel_valid_reg)
            off_reg <= off_next;
    end

    // ---------------- divider stages
    // Remainder is at most the divisor after the first step, so a left shift fits CB+1 bits.
    function automatic cmfs_pkg::div_t div_steps(cmfs_pkg::div_t s, int base);
        cmfs_pkg::div_t t;
        logic [CB:0]    d;
        int             k;
        t = s;
        d = {1'b0, s.div};
        for (int j = 0; j < STEPS_PER_STAGE; j++)
        begin
            k = base + j;
            if (k < FB)
            begin
                if (k != 0)
                begin
                    t.rem_u = {t.rem_u[CB-1:0], 1'b0};
                    t.rem_v = {t.rem_v[CB-1:0], 1'b0};
                end
                if (t.rem_u >= d)
                begin
                    t.rem_u = t.rem_u - d;
                    t.quo_u = {t.quo_u[FB-2:0], 1'b1};
                end
                else
                    t.quo_u = {t.quo_u[FB-2:0], 1'b0};
                if (t.rem_v >= d)
                begin
                    t.rem_v = t.rem_v - d;
                    t.quo_v = {t.quo_v[FB-2:0], 1'b1};
                end
                else
                    t.quo_v = {t.quo_v[FB-2:0], 1'b0};
            end
        end
        return t;
    endfunction

    logic [NSTAGE-1:0] div_valid_reg;
    cmfs_pkg::div_t    div_reg  [NSTAGE];
    cmfs_pkg::div_t    div_next [NSTAGE];

    genvar g;
    generate
        for (g = 0; g < NSTAGE; g++)
        begin : g_div
            if (g == 0)
            begin : g_first
                always_comb
                begin
                    div_next[g] = div_steps(off_reg, 0);
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        div_valid_reg[g] <= 1'b0;
                    else
                        div_valid_reg[g] <= off_valid_reg;
                end

                always_ff @(posedge clk)
                begin
                    if (off_valid_reg)
                        div_reg[g] <= div_next[g];
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    div_next[g] = div_steps(div_reg[g-1], g * STEPS_PER_STAGE);
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        div_valid_reg[g] <= 1'b0;
                    else
                        div_valid_reg[g] <= div_valid_reg[g-1];
                end

                always_ff @(posedge clk)
                begin
                    if (div_valid_reg[g-1])
                        div_reg[g] <= div_next[g];
                end
            end
        end
    endgenerate

    // ---------------- output register
    logic              done_reg;
    cmfs_pkg::result_t result_reg;
    cmfs_pkg::result_t result_next;
    cmfs_pkg::div_t    last;

    assign last = div_reg[NSTAGE-1];

    always_comb
    begin
        if (last.zero)
        begin
            result_next.face        = cmfs_pkg::FACE_NZ;
            result_next.coord_u     = cmfs_pkg::COORD_HALF;
            result_next.coord_v     = cmfs_pkg::COORD_HALF;
            result_next.zero_vector = 1'b1;
        end
        else
        begin
            result_next.face        = last.face;
            result_next.coord_u     = last.sat_u ? cmfs_pkg::COORD_MAX : last.quo_u;
            result_next.coord_v     = last.sat_v ? cmfs_pkg::COORD_MAX : last.quo_v;
            result_next.zero_vector = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid_reg[NSTAGE-1];
    end

    always_ff @(posedge clk)
    begin
        if (div_valid_reg[NSTAGE-1])
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- assertions
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("item did not come out after the pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result without a matching item");

    a_zero_center: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_vector) |->
            (result.face == cmfs_pkg::FACE_NZ && result.coord_u == cmfs_pkg::COORD_HALF
             && result.coord_v == cmfs_pkg::COORD_HALF))
        else $error("zero vector result is not the -Z center");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.face <= cmfs_pkg::FACE_NZ))
        else $error("face index out of range");

endmodule

/* bench/cube_map_face_check.sv */
// Checker for the cube map face select unit: predicts face and u/v per item and compares.
`timescale 1ns / 100ps

module cube_map_face_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  cmfs_pkg::dir_t    dir,
    input  logic              done,
    input  cmfs_pkg::result_t result,
    input  logic              wrap_up,
    output int                errors,
    output int                pending
);
    import cmfs_pkg::*;

    result_t due_results[$];
    result_t want;
    bit      wrapped = 1'b0;

    task automatic report(input string what);
        begin
            $display("%0t mismatch: %s", $realtime, what);
            errors++;
        end
    endtask

    // (minor + major) / (2 * major) scaled to Q0.16, clipped at full scale
    function automatic logic [FRAC_BITS-1:0] ratio_coord(input logic signed [17:0] minor,
                                                         input logic [16:0] major);
        logic [63:0] num;
        logic [63:0] q;
        begin
            num = 64'(minor + $signed({1'b0, major})) << (FRAC_BITS - 1);
            q = num / {47'd0, major};
            return (q > 64'(COORD_MAX)) ? COORD_MAX : q[FRAC_BITS-1:0];
        end
    endfunction

    function automatic result_t face_uv(input dir_t d);
        logic signed [17:0] x, y, z, mu, mv;
        logic [16:0]        ax, ay, az, major;
        logic [2:0]         f;
        result_t            r;
        begin
            x = d.dir_x;
            y = d.dir_y;
            z = d.dir_z;
            ax = 17'(x < 0 ? -x : x);
            ay = 17'(y < 0 ? -y : y);
            az = 17'(z < 0 ? -z : z);
            major = ax; mu = -z; mv = y; f = FACE_PX;
            // later tests win ties
            if (x <= 0 && ax >= ay && ax >= az)
            begin
                major = ax; mu = z;  mv = y;  f = FACE_NX;
            end
            if (y > 0  && ay >= ax && ay >= az)
            begin
                major = ay; mu = x;  mv = -z; f = FACE_PY;
            end
            if (y <= 0 && ay >= ax && ay >= az)
            begin
                major = ay; mu = x;  mv = z;  f = FACE_NY;
            end
            if (z > 0  && az >= ax && az >= ay)
            begin
                major = az; mu = x;  mv = y;  f = FACE_PZ;
            end
            if (z <= 0 && az >= ax && az >= ay)
            begin
                major = az; mu = -x; mv = y;  f = FACE_NZ;
            end
            if (major == 0)
                r = '{face: FACE_NZ, coord_u: COORD_HALF, coord_v: COORD_HALF, zero_vector: 1'b1};
            else
                r = '{face: f, coord_u: ratio_coord(mu, major), coord_v: ratio_coord(mv, major),
                      zero_vector: 1'b0};
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
                due_results.push_back(face_uv(dir));
            if (done)
            begin
                if (due_results.size() == 0)
                    report("result with no item outstanding");
                else
                begin
                    want = due_results.pop_front();
                    if (result.face !== want.face)
                        report($sformatf("face got %0d want %0d", result.face, want.face));
                    if (result.coord_u !== want.coord_u)
                        report($sformatf("coord_u got %0d want %0d", result.coord_u,
                                         want.coord_u));
                    if (result.coord_v !== want.coord_v)
                        report($sformatf("coord_v got %0d want %0d", result.coord_v,
                                         want.coord_v));
                    if (result.zero_vector !== want.zero_vector)
                        report($sformatf("zero_vector got %0b want %0b", result.zero_vector,
                                         want.zero_vector));
                end
            end
            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                while (due_results.size() != 0)
                begin
                    void'(due_results.pop_front());
                    report("expected result never arrived");
                end
            end
            pending <= due_results.size();
        end
    end

endmodule

/* bench/cube_map_face_select_unit_tb.sv */
// Testbench top for the cube map face select unit: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module cube_map_face_select_unit_tb;
    import cmfs_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 16;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    dir_t    dir;
    logic    done;
    result_t result;
    logic    wrap_up;
    int      errors;
    int      pending;
    int      quiet_cycles;
    bit      idle_on;

    cube_map_face_select_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .dir    (dir),
        .done   (done),
        .result (result)
    );

    cube_map_face_check check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dir     (dir),
        .done    (done),
        .result  (result),
        .wrap_up (wrap_up),
        .errors  (errors),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // stuck if no item goes in and no result comes out for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("cube_map_face_select_unit test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_dir(input int x, input int y, input int z);
        dir_t d;
        begin
            d.dir_x = 16'(x);
            d.dir_y = 16'(y);
            d.dir_z = 16'(z);
            while (idle_on && $urandom_range(0, 99) < 20)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            dir   <= d;
            do
                @(posedge clk);
            while (busy);
        end
    endtask

    task automatic wait_drained;
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (pending != 0);
        end
    endtask

    function automatic int rand_comp;
        begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: return $signed(16'($urandom));
                4, 5:       return int'($urandom_range(0, 8)) - 4;
                default:
                    case ($urandom_range(0, 5))
                        0: return -32768;
                        1: return -32767;
                        2: return -1;
                        3: return 0;
                        4: return 1;
                        default: return 32767;
                    endcase
            endcase
        end
    endfunction

    initial
    begin
        int x, y, z;
        rst_n   = 1'b0;
        start   = 1'b0;
        dir     = '0;
        wrap_up = 1'b0;
        idle_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // axes, extremes, ties, full scale, zero vector
        send_dir(0, 0, 0);
        send_dir(32767, 0, 0);
        send_dir(-32768, 0, 0);
        send_dir(0, 32767, 0);
        send_dir(0, -32768, 0);
        send_dir(0, 0, 32767);
        send_dir(0, 0, -32768);
        send_dir(100, 100, 0);
        send_dir(-32768, -32768, -32768);
        send_dir(32767, 32767, 32767);
        send_dir(-100, 0, 100);
        send_dir(1, 0, 0);
        send_dir(-1, 1, -1);
        send_dir(0, 0, 1);
        send_dir(0, -1, 0);
        send_dir(-32768, 32767, -32767);
        send_dir(5, -3, 2);
        send_dir(32767, -32768, 0);
        send_dir(-1, -1, 0);
        send_dir(7, 0, -7);
        send_dir(0, 0, 0);

        // let everything drain before the random part
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = !(n >= 400 && n < 700);
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            // equal magnitudes exercise the tie order
            case ($urandom_range(0, 5))
                0: y = $urandom_range(0, 1) ? x : -x;
                1: z = $urandom_range(0, 1) ? y : -y;
                2: z = $urandom_range(0, 1) ? x : -x;
                default: ;
            endcase
            send_dir(x, y, z);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        if (errors == 0)
            $display("cube_map_face_select_unit test passed");
        else
            $display("cube_map_face_select_unit test failed");
        $finish;
    end

endmodule

/* cube_map_face_select_unit.f */
rtl/core/cmfs_pkg.sv
rtl/core/cube_map_face_select_unit.sv
bench/cube_map_face_check.sv
bench/cube_map_face_select_unit_tb.sv
